>>> rtl/core/pls_pkg.sv
package pls_pkg;

  localparam int COORD_BITS  = 16;
  localparam int PAUSE_BYTES = 30;

  localparam int SPAN_W  = COORD_BITS + 1;
  localparam int ACC_W   = COORD_BITS + 2;
  localparam int PAUSE_W = $clog2(PAUSE_BYTES + 2);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] REQ_MOVE = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_PEN  = 2'd2;

  localparam logic [3:0] STEP_PX = 4'h1;
  localparam logic [3:0] STEP_MX = 4'h2;
  localparam logic [3:0] STEP_PY = 4'h4;
  localparam logic [3:0] STEP_MY = 4'h8;

  localparam logic [5:0] PEN_UP     = 6'h10;
  localparam logic [5:0] PEN_MASK   = 6'h30;
  localparam logic [5:0] PAUSE_BYTE = 6'h00;

  typedef enum logic [1:0] {
    KIND_MOVE,
    KIND_TICK,
    KIND_PEN
  } kind_t;

  typedef struct packed {
    kind_t                         kind;
    logic signed [COORD_BITS-1:0]  tx;
    logic signed [COORD_BITS-1:0]  ty;
    logic [5:0]                    pen;
  } entry_t;

endpackage

>>> rtl/core/pls_front.sv
module pls_front
  import pls_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic signed [COORD_BITS-1:0] target_x,
  input  logic signed [COORD_BITS-1:0] target_y,
  input  logic [5:0]                   pen_code,
  output logic                         push_valid,
  input  logic                         push_ready,
  output entry_t                       push_data
);

  logic [5:0] pen_state;
  logic       pen_change;

  assign in_ready   = push_ready;
  assign pen_change = pen_code != pen_state;

  always_comb begin
    push_data.tx  = target_x;
    push_data.ty  = target_y;
    push_data.pen = pen_code & PEN_MASK;
    unique case (req_type)
      REQ_MOVE: begin
        push_data.kind = KIND_MOVE;
        push_valid     = in_valid;
      end
      REQ_TICK: begin
        push_data.kind = KIND_TICK;
        push_valid     = in_valid;
      end
      REQ_PEN: begin
        push_data.kind = KIND_PEN;
        push_valid     = in_valid && pen_change;
      end
      default: begin
        // drop the unused request code
        push_data.kind = KIND_TICK;
        push_valid     = 1'b0;
      end
    endcase
  end

  // Pen filter lives here: only pen items change it, in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_state <= PEN_UP;
    end else if (in_valid && in_ready && req_type == REQ_PEN && pen_change) begin
      pen_state <= pen_code & PEN_MASK;
    end
  end

endmodule

>>> rtl/core/pls_queue.sv
module pls_queue
  import pls_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_data
);

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/pls_back.sv
module pls_back
  import pls_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  output logic                         head_pop,
  input  entry_t                       head,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [5:0]                   plot_byte,
  output logic signed [COORD_BITS-1:0] pos_x,
  output logic signed [COORD_BITS-1:0] pos_y,
  output logic                         last
);

  logic signed [COORD_BITS-1:0] cur_x, cur_x_next;
  logic signed [COORD_BITS-1:0] cur_y, cur_y_next;
  logic [SPAN_W-1:0]            steps_left, steps_left_next;
  logic [SPAN_W-1:0]            major_span, major_span_next;
  logic [SPAN_W-1:0]            minor_span, minor_span_next;
  logic signed [ACC_W-1:0]      acc, acc_next;
  logic [3:0]                   major_code, major_code_next;
  logic [3:0]                   minor_code, minor_code_next;
  logic [PAUSE_W-1:0]           pause_left, pause_left_next;

  logic                         out_free;
  logic                         emit;
  logic [5:0]                   emit_byte;
  logic                         emit_last;

  // move decode
  logic signed [SPAN_W-1:0]     dx, dy;
  logic [SPAN_W-1:0]            ax, ay;
  logic                         y_major;

  // tick step
  logic                         take_minor;
  logic [3:0]                   step_bits;
  logic signed [COORD_BITS-1:0] x_delta, y_delta;
  logic signed [ACC_W-1:0]      two_minor, two_major;

  assign out_free = !out_valid || out_ready;

  assign dx = $signed({head.tx[COORD_BITS-1], head.tx}) - $signed({cur_x[COORD_BITS-1], cur_x});
  assign dy = $signed({head.ty[COORD_BITS-1], head.ty}) - $signed({cur_y[COORD_BITS-1], cur_y});
  assign ax = dx[SPAN_W-1] ? (~dx + 1'b1) : dx;
  assign ay = dy[SPAN_W-1] ? (~dy + 1'b1) : dy;
  assign y_major = ay > ax;

  assign two_minor  = $signed({minor_span, 1'b0});
  assign two_major  = $signed({major_span, 1'b0});
  assign take_minor = acc > 0;
  assign step_bits  = major_code | (take_minor ? minor_code : 4'h0);

  always_comb begin
    if ((step_bits & STEP_PX) != 4'h0) begin
      x_delta = COORD_BITS'(1);
    end else if ((step_bits & STEP_MX) != 4'h0) begin
      x_delta = '1;
    end else begin
      x_delta = '0;
    end
    if ((step_bits & STEP_PY) != 4'h0) begin
      y_delta = COORD_BITS'(1);
    end else if ((step_bits & STEP_MY) != 4'h0) begin
      y_delta = '1;
    end else begin
      y_delta = '0;
    end
  end

  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    steps_left_next = steps_left;
    major_span_next = major_span;
    minor_span_next = minor_span;
    acc_next        = acc;
    major_code_next = major_code;
    minor_code_next = minor_code;
    pause_left_next = pause_left;
    head_pop        = 1'b0;
    emit            = 1'b0;
    emit_byte       = PAUSE_BYTE;
    emit_last       = 1'b0;

    if (pause_left != '0) begin
      // a pen change owns the output until its pauses are out
      if (out_free) begin
        emit            = 1'b1;
        emit_last       = pause_left == PAUSE_W'(1);
        pause_left_next = pause_left - 1'b1;
      end
    end else if (head_valid) begin
      case (head.kind)
        KIND_MOVE: begin
          head_pop = 1'b1;
          if (y_major) begin
            major_span_next = ay;
            minor_span_next = ax;
            major_code_next = dy[SPAN_W-1] ? STEP_MY : STEP_PY;
            minor_code_next = dx[SPAN_W-1] ? STEP_MX : STEP_PX;
          end else begin
            major_span_next = ax;
            minor_span_next = ay;
            major_code_next = dx[SPAN_W-1] ? STEP_MX : STEP_PX;
            minor_code_next = dy[SPAN_W-1] ? STEP_MY : STEP_PY;
          end
          steps_left_next = major_span_next;
          acc_next = $signed({minor_span_next, 1'b0}) - $signed({1'b0, major_span_next});
        end
        KIND_TICK: begin
          if (steps_left == '0) begin
            head_pop = 1'b1;
          end else if (out_free) begin
            head_pop        = 1'b1;
            emit            = 1'b1;
            emit_byte       = {2'b00, step_bits};
            emit_last       = steps_left == SPAN_W'(1);
            cur_x_next      = cur_x + x_delta;
            cur_y_next      = cur_y + y_delta;
            steps_left_next = steps_left - 1'b1;
            acc_next        = acc + two_minor - (take_minor ? two_major : '0);
          end
        end
        KIND_PEN: begin
          if (out_free) begin
            head_pop        = 1'b1;
            emit            = 1'b1;
            emit_byte       = head.pen;
            emit_last       = PAUSE_BYTES == 0;
            pause_left_next = PAUSE_W'(PAUSE_BYTES);
          end
        end
        default: begin
          head_pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      steps_left <= '0;
      major_span <= '0;
      minor_span <= '0;
      acc        <= '0;
      major_code <= STEP_PX;
      minor_code <= STEP_PY;
      pause_left <= '0;
      out_valid  <= 1'b0;
    end else begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      steps_left <= steps_left_next;
      major_span <= major_span_next;
      minor_span <= minor_span_next;
      acc        <= acc_next;
      major_code <= major_code_next;
      minor_code <= minor_code_next;
      pause_left <= pause_left_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      plot_byte <= emit_byte;
      pos_x     <= cur_x_next;
      pos_y     <= cur_y_next;
      last      <= emit_last;
    end
  end

endmodule

>>> rtl/core/plotter_line_stepper.sv
// Path: a tick or pen item's first byte reaches the output through the queue write, then the
// output register of the step engine, when the queue is empty and the output is free.
// Throughput: one item per cycle while the output is not stalled; a pen change holds the
// engine while its pen byte and then its PAUSE_BYTES pause bytes go out, one per cycle
// while the output is free.
// Reset (synchronous, active high): queue empty, pen at (0,0), pen up, no run in progress.
module plotter_line_stepper
  import pls_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic signed [COORD_BITS-1:0] target_x,
  input  logic signed [COORD_BITS-1:0] target_y,
  input  logic [5:0]                   pen_code,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [5:0]                   plot_byte,
  output logic signed [COORD_BITS-1:0] pos_x,
  output logic signed [COORD_BITS-1:0] pos_y,
  output logic                         last
);

  // Front: classify requests, drop unused codes and repeated pens.
  logic   push_valid;
  logic   push_ready;
  entry_t push_data;

  // Back: the step engine pulls entries in order.
  logic   head_valid;
  logic   head_pop;
  entry_t head;

  pls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .target_x   (target_x),
    .target_y   (target_y),
    .pen_code   (pen_code),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Short queue decouples input transfers from output stalls.
  pls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_data   (head)
  );

  // Move decode, Bresenham stepping, pen byte and pause sequencing.
  pls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head       (head),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .plot_byte  (plot_byte),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .last       (last)
  );

  // Moves and ticks always enter the queue; only pen and unused codes may be dropped.
  a_front_keeps_moves: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type == REQ_MOVE || req_type == REQ_TICK) |-> push_valid)
    else $error("move or tick transfer not queued");

  // Never pop an empty queue.
  a_pop_when_valid: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head_valid)
    else $error("step engine popped an empty queue");

  // A step byte never carries pen bits.
  a_byte_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> plot_byte[3:0] == 4'h0 || plot_byte[5:4] == 2'b00)
    else $error("plot byte mixes step and pen bits");

  // A pen byte is final only when no pauses follow it.
  a_pen_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && plot_byte[5:4] != 2'b00 |-> last == (PAUSE_BYTES == 0))
    else $error("pen byte last flag wrong");

endmodule
